[design/fir_two_to_one_resampler_defines.svh]
// assertion helpers used by the checker
`ifndef FIR_TWO_TO_ONE_RESAMPLER_DEFINES_SVH
`define FIR_TWO_TO_ONE_RESAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define FRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define FRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/frr_pkg.sv]
package frr_pkg;

    // filter geometry
    localparam int TAP_COUNT = 31;
    localparam int COEF_BITS = 18;
    localparam int COEF_FRAC = COEF_BITS - 1;
    localparam int SAMPLE_W  = 24;
    localparam int TAP_W     = $clog2(TAP_COUNT);
    localparam int PROD_W    = SAMPLE_W + COEF_BITS;
    localparam int ACC_W     = PROD_W + TAP_W;

    // configuration port
    localparam int REG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_RATE_MODE     = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_STEREO_ENABLE = 1'b1;

    // saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] ACC_SAT_HI = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_SAT_LO = -(ACC_W'(1) <<< (SAMPLE_W - 1));

    // hamming-windowed sinc, cutoff 0.25, unity dc gain, q1.17
    localparam logic signed [COEF_BITS-1:0] COEF_TABLE [TAP_COUNT] = '{
        -18'sd223,   18'sd0,  18'sd385,    18'sd0,  -18'sd882,   18'sd0,
        18'sd1847,   18'sd0, -18'sd3511,   18'sd0,  18'sd6436,   18'sd0,
        -18'sd12706, 18'sd0,  18'sd41369,  18'sd65642,
        18'sd41369,  18'sd0, -18'sd12706,  18'sd0,  18'sd6436,   18'sd0,
        -18'sd3511,  18'sd0,  18'sd1847,   18'sd0, -18'sd882,    18'sd0,
        18'sd385,    18'sd0, -18'sd223
    };

    // microprogram addresses
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UA_FETCH  = 3'd0;
    localparam logic [UPC_W-1:0] UA_MAC    = 3'd1;
    localparam logic [UPC_W-1:0] UA_DRAIN  = 3'd2;
    localparam logic [UPC_W-1:0] UA_EMIT   = 3'd3;
    localparam logic [UPC_W-1:0] UA_ZSHIFT = 3'd4;

    // sequencing conditions
    typedef enum logic [2:0] {
        JC_NEXT  = 3'd0,
        JC_FETCH = 3'd1,
        JC_MAC   = 3'd2,
        JC_EMIT  = 3'd3,
        JC_GOTO  = 3'd4
    } jump_t;

    typedef struct packed {
        logic              in_rdy;
        logic              mac_en;
        logic              emit_en;
        logic              zshift_en;
        jump_t             jump;
        logic [UPC_W-1:0]  target;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '{in_rdy: 1'b0, mac_en: 1'b0, emit_en: 1'b0, zshift_en: 1'b0,
              jump: JC_GOTO, target: UA_FETCH};
        case (addr)
            UA_FETCH:
            begin
                w.in_rdy = 1'b1;
                w.jump   = JC_FETCH;
                w.target = UA_FETCH;
            end
            UA_MAC:
            begin
                w.mac_en = 1'b1;
                w.jump   = JC_MAC;
                w.target = UA_MAC;
            end
            UA_DRAIN:
            begin
                w.jump   = JC_NEXT;
                w.target = UA_EMIT;
            end
            UA_EMIT:
            begin
                w.emit_en = 1'b1;
                w.jump    = JC_EMIT;
                w.target  = UA_FETCH;
            end
            UA_ZSHIFT:
            begin
                w.zshift_en = 1'b1;
                w.jump      = JC_GOTO;
                w.target    = UA_MAC;
            end
            default:
            begin
                w.jump   = JC_GOTO;
                w.target = UA_FETCH;
            end
        endcase
        return w;
    endfunction

    // round to nearest (ties up), gain 2 drops one fewer fraction bit, then saturate
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc,
        input logic                    gain2
    );
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] q;
        logic signed [SAMPLE_W-1:0] res;
        bias = gain2 ? (ACC_W'(1) <<< (COEF_FRAC - 2)) : (ACC_W'(1) <<< (COEF_FRAC - 1));
        sum  = acc + bias;
        q    = gain2 ? (sum >>> (COEF_FRAC - 1)) : (sum >>> COEF_FRAC);
        if (q > ACC_SAT_HI)
        begin
            res = ACC_SAT_HI[SAMPLE_W-1:0];
        end
        else if (q < ACC_SAT_LO)
        begin
            res = ACC_SAT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            res = q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

[design/fir_two_to_one_resampler.sv]
// 2:1 audio resampler, mono or stereo, 24-bit samples, one 31-tap hamming-windowed
// sinc fir (cutoff 0.25, unity dc gain) shared by both directions. rate_mode 0
// decimates: every frame enters the history and every second frame of a run gives
// one beat. rate_mode 1 interpolates: every frame gives two beats, the first with
// the sample shifted in, the second with a zero shifted in, both at gain 2, and
// last_of_run marks the second. block_end restarts the decimation phase after its
// frame; a clear beat (action 1) zeroes both histories and the phase and gives no
// result. one shared 24x18 multiply-accumulate walks all taps, alternating left and
// right, so a filtered beat runs mac steps over every tap and channel, then the
// drain and output steps, while a decimate frame on the even phase or a clear is
// taken in the fetch step alone. the result sits in an output
// register, so the next frame is taken while the last beat waits downstream; a
// second result only stalls when the previous one has not been taken yet.
// configuration must only be written while the block is idle; the block does not enforce this.
module fir_two_to_one_resampler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [frr_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [frr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [frr_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [frr_pkg::SAMPLE_W-1:0] right_sample,
    input  logic                                block_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [frr_pkg::SAMPLE_W-1:0] left_result,
    output logic signed [frr_pkg::SAMPLE_W-1:0] right_result,
    output logic                                last_of_run
);
    import frr_pkg::*;

    // configuration
    logic rate_mode_reg;
    logic stereo_enable_reg;

    // sequencer
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uw;

    // filter state
    logic signed [SAMPLE_W-1:0] hist_l_reg [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] hist_r_reg [TAP_COUNT];
    logic                       odd_phase_reg;
    logic                       odd_phase_next;
    logic                       pass_reg;

    // mac datapath
    logic [TAP_W-1:0]           tap_reg;
    logic                       chan_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    logic                       prod_chan_reg;
    logic signed [ACC_W-1:0]    acc_l_reg;
    logic signed [ACC_W-1:0]    acc_r_reg;
    logic signed [SAMPLE_W-1:0] sample_sel;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic                       out_last_reg;

    // decoded control
    logic                       in_fire;
    logic                       frame_fire;
    logic                       clear_fire;
    logic                       need_result;
    logic                       mac_last;
    logic                       out_free;
    logic                       emit_fire;
    logic                       interp_more;
    logic                       shift_en;
    logic signed [SAMPLE_W-1:0] shift_l;
    logic signed [SAMPLE_W-1:0] shift_r;

    assign uw          = ucode_rom(upc_reg);
    assign in_ready    = uw.in_rdy;
    assign in_fire     = in_valid & in_ready;
    assign frame_fire  = in_fire & ~action;
    assign clear_fire  = in_fire & action;
    // decimate only filters on the odd phase, interpolate always does
    assign need_result = rate_mode_reg | odd_phase_reg;
    assign mac_last    = (tap_reg == TAP_W'(TAP_COUNT - 1)) & chan_reg;
    assign out_free    = ~out_valid_reg | out_ready;
    assign emit_fire   = uw.emit_en & out_free;
    // first pass of an interpolated frame, a zero-stuffed pass still follows
    assign interp_more = rate_mode_reg & ~pass_reg;

    // history shifts on a new frame or on the zero-stuff step
    assign shift_en = frame_fire | uw.zshift_en;
    assign shift_l  = frame_fire ? left_sample  : '0;
    assign shift_r  = frame_fire ? right_sample : '0;

    assign sample_sel = chan_reg ? hist_r_reg[tap_reg] : hist_l_reg[tap_reg];

    // step counter with conditional jumps
    always_comb
    begin
        upc_next = upc_reg;
        case (uw.jump)
            JC_NEXT:  upc_next = upc_reg + UPC_W'(1);
            JC_FETCH: upc_next = (frame_fire & need_result) ? upc_reg + UPC_W'(1) : upc_reg;
            JC_MAC:   upc_next = mac_last ? upc_reg + UPC_W'(1) : upc_reg;
            JC_EMIT:
            begin
                if (!out_free)
                begin
                    upc_next = upc_reg;
                end
                else if (interp_more)
                begin
                    upc_next = upc_reg + UPC_W'(1);
                end
                else
                begin
                    upc_next = uw.target;
                end
            end
            JC_GOTO:  upc_next = uw.target;
            default:  upc_next = UA_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mode_reg     <= 1'b0;
            stereo_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATE_MODE:     rate_mode_reg     <= cfg_data[0];
                REG_STEREO_ENABLE: stereo_enable_reg <= cfg_data[0];
                default:           rate_mode_reg     <= rate_mode_reg;
            endcase
        end
    end

    // decimation phase: toggles per decimated frame, block_end or a clear restarts it
    always_comb
    begin
        odd_phase_next = odd_phase_reg;
        if (clear_fire)
        begin
            odd_phase_next = 1'b0;
        end
        else if (frame_fire)
        begin
            if (block_end)
            begin
                odd_phase_next = 1'b0;
            end
            else if (!rate_mode_reg)
            begin
                odd_phase_next = ~odd_phase_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_phase_reg <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            odd_phase_reg <= odd_phase_next;
            if (frame_fire)
            begin
                pass_reg <= 1'b0;
            end
            else if (uw.zshift_en)
            begin
                pass_reg <= 1'b1;
            end
        end
    end

    // sample histories, newest at index 0; right side frozen in mono
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else if (clear_fire)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            hist_l_reg[0] <= shift_l;
            for (int i = 1; i < TAP_COUNT; i++)
            begin
                hist_l_reg[i] <= hist_l_reg[i-1];
            end
            if (stereo_enable_reg)
            begin
                hist_r_reg[0] <= shift_r;
                for (int i = 1; i < TAP_COUNT; i++)
                begin
                    hist_r_reg[i] <= hist_r_reg[i-1];
                end
            end
        end
    end

    // tap walk: left then right for each tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg      <= '0;
            chan_reg     <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= uw.mac_en;
            if (uw.mac_en)
            begin
                chan_reg <= ~chan_reg;
                if (chan_reg)
                begin
                    tap_reg <= mac_last ? '0 : tap_reg + TAP_W'(1);
                end
            end
        end
    end

    // registered product
    always_ff @(posedge clk)
    begin
        prod_reg      <= COEF_TABLE[tap_reg] * sample_sel;
        prod_chan_reg <= chan_reg;
    end

    // accumulators, cleared once a result is taken into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (emit_fire)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            if (prod_chan_reg)
            begin
                acc_r_reg <= acc_r_reg + ACC_W'(prod_reg);
            end
            else
            begin
                acc_l_reg <= acc_l_reg + ACC_W'(prod_reg);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_left_reg  <= round_sat(acc_l_reg, rate_mode_reg);
            out_right_reg <= stereo_enable_reg ? round_sat(acc_r_reg, rate_mode_reg) : '0;
            out_last_reg  <= ~interp_more;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_result  = out_left_reg;
    assign right_result = out_right_reg;
    assign last_of_run  = out_last_reg;

endmodule

[design/frr_checker.sv]
`include "fir_two_to_one_resampler_defines.svh"

module frr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                action,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [frr_pkg::SAMPLE_W-1:0] left_result,
    input logic signed [frr_pkg::SAMPLE_W-1:0] right_result,
    input logic                                last_of_run
);

    // a stalled result beat holds its payload
    `FRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_result) && $stable(right_result) && $stable(last_of_run), "stalled result beat changed")

    // first beat of an interpolated pair leaves the block still busy on the second
    `FRR_ASSERT_NOW(a_pair_busy, out_valid && out_ready && !last_of_run, !in_ready, "input taken between the two beats of a pair")

    // a clear beat returns straight to input fetch
    `FRR_ASSERT_NEXT(a_clear_ready, in_valid && in_ready && action, in_ready, "clear beat did not return to fetch")

    // a clear beat never produces a result
    `FRR_ASSERT_NEXT(a_clear_quiet, in_valid && in_ready && action, !$rose(out_valid), "clear beat produced a result")

endmodule

bind fir_two_to_one_resampler frr_checker u_frr_checker (.*);

[sim/tb_fir_two_to_one_resampler.sv]
`timescale 1ns / 100ps

module tb_fir_two_to_one_resampler;
    import frr_pkg::*;

    // input beat kinds
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // rate_mode register values
    localparam logic RATE_DECIMATE    = 1'b0;
    localparam logic RATE_INTERPOLATE = 1'b1;

    // stereo_enable register values
    localparam logic CH_MONO   = 1'b0;
    localparam logic CH_STEREO = 1'b1;

    // sample value styles for the random traffic
    localparam int FLAVOR_FULL    = 0;
    localparam int FLAVOR_QUIET   = 1;
    localparam int FLAVOR_EXTREME = 2;

    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_POS = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_NEG = 24'sh800000;

    // idle time that lets a busy block settle
    localparam int IDLE_SETTLE   = 200;
    localparam int RANDOM_FRAMES = 1000;

    // windowed sinc taps, q1.17, written out independently of the design rom
    localparam int TAP_WEIGHT [TAP_COUNT] = '{
        -223, 0, 385, 0, -882, 0, 1847, 0, -3511, 0, 6436, 0, -12706, 0, 41369,
        65642,
        41369, 0, -12706, 0, 6436, 0, -3511, 0, 1847, 0, -882, 0, 385, 0, -223
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_val;
        logic signed [SAMPLE_W-1:0] right_val;
        logic                       last_flag;
    } audio_beat_t;

    // clock, reset and every block input start at known values
    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_we       = 1'b0;
    logic [REG_IDX_W-1:0]         cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_data     = '0;
    logic                         in_valid     = 1'b0;
    logic                         action       = 1'b0;
    logic signed [SAMPLE_W-1:0]   left_sample  = '0;
    logic signed [SAMPLE_W-1:0]   right_sample = '0;
    logic                         block_end    = 1'b0;
    logic                         out_ready    = 1'b0;
    logic                         in_ready;
    logic                         out_valid;
    logic signed [SAMPLE_W-1:0]   left_result;
    logic signed [SAMPLE_W-1:0]   right_result;
    logic                         last_of_run;

    // resampler shadow: tap histories, decimation phase and register copies
    logic signed [SAMPLE_W-1:0]   left_taps  [TAP_COUNT];
    logic signed [SAMPLE_W-1:0]   right_taps [TAP_COUNT];
    logic                         odd_phase_q;
    logic                         rate_mode_q;
    logic                         stereo_q;

    // filtered beats still owed by the block, oldest first
    audio_beat_t                  pending_beats [$];
    int                           mismatch_count = 0;
    bit                           gaps_on        = 1'b1;
    int                           ready_stall    = 0;

    fir_two_to_one_resampler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .block_end    (block_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_result  (left_result),
        .right_result (right_result),
        .last_of_run  (last_of_run)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle length: half back-to-back, most of the rest short, a few long
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int flavor);
        int v;
        if (flavor == FLAVOR_FULL)
            return SAMPLE_W'($urandom());
        if (flavor == FLAVOR_QUIET)
        begin
            v = $urandom_range(0, 2047);
            return SAMPLE_W'(v - 1024);
        end
        case ($urandom_range(0, 3))
            0: return FULL_SCALE_POS;
            1: return FULL_SCALE_NEG;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // exact dot product over the taps, round to nearest (ties up), saturate
    function automatic logic signed [SAMPLE_W-1:0] filter_tap_sum(input logic right_ch,
                                                                 input logic gain2);
        longint acc;
        longint scaled;
        int     k;
        acc = 0;
        for (k = 0; k < TAP_COUNT; k++)
        begin
            if (right_ch)
                acc += longint'(TAP_WEIGHT[k]) * longint'(right_taps[k]);
            else
                acc += longint'(TAP_WEIGHT[k]) * longint'(left_taps[k]);
        end
        // gain 2 keeps one more integer bit, i.e. drops one less fraction bit
        if (gain2)
            scaled = (acc + (longint'(1) << (COEF_FRAC - 2))) >>> (COEF_FRAC - 1);
        else
            scaled = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (scaled > longint'(FULL_SCALE_POS))
            return FULL_SCALE_POS;
        if (scaled < longint'(FULL_SCALE_NEG))
            return FULL_SCALE_NEG;
        return scaled[SAMPLE_W-1:0];
    endfunction

    // newest sample lands at tap 0; right history is frozen in mono
    function automatic void shift_frame(input logic signed [SAMPLE_W-1:0] l,
                                        input logic signed [SAMPLE_W-1:0] r);
        int k;
        for (k = TAP_COUNT - 1; k > 0; k--)
        begin
            left_taps[k] = left_taps[k-1];
            if (stereo_q)
                right_taps[k] = right_taps[k-1];
        end
        left_taps[0] = l;
        if (stereo_q)
            right_taps[0] = r;
    endfunction

    function automatic void owe_result(input logic gain2, input logic last_beat);
        audio_beat_t b;
        b.left_val  = filter_tap_sum(1'b0, gain2);
        b.right_val = stereo_q ? filter_tap_sum(1'b1, gain2) : '0;
        b.last_flag = last_beat;
        pending_beats.push_back(b);
    endfunction

    function automatic void clear_history();
        int k;
        for (k = 0; k < TAP_COUNT; k++)
        begin
            left_taps[k]  = '0;
            right_taps[k] = '0;
        end
        odd_phase_q = 1'b0;
    endfunction

    // what one accepted input beat owes downstream
    function automatic void resample_frame(input logic act,
                                           input logic signed [SAMPLE_W-1:0] l,
                                           input logic signed [SAMPLE_W-1:0] r,
                                           input logic be);
        if (act == ACT_CLEAR)
        begin
            clear_history();
            return;
        end
        shift_frame(l, r);
        if (rate_mode_q == RATE_DECIMATE)
        begin
            // only the odd phase of a run yields a beat
            if (odd_phase_q)
                owe_result(1'b0, 1'b1);
            odd_phase_q = ~odd_phase_q;
        end
        else
        begin
            // sample beat, then the zero-stuffed beat which closes the pair
            owe_result(1'b1, 1'b0);
            shift_frame('0, '0);
            owe_result(1'b1, 1'b1);
        end
        // interpolate mode leaves the phase alone except for block end
        if (be)
            odd_phase_q = 1'b0;
    endfunction

    // one input beat: optional idle gap, then hold valid until in_ready
    task automatic send_frame(input logic act,
                              input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r,
                              input logic be);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        left_sample  <= l;
        right_sample <= r;
        block_end    <= be;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        resample_frame(act, l, r, be);
    endtask

    task automatic rest_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // registers only change with nothing in flight; a frame that owes no
    // beat may still be inside the block, hence the settle time
    task automatic set_mode(input logic rate, input logic stereo);
        rest_input();
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RATE_MODE;
        cfg_data  <= rate;
        @(negedge clk);
        cfg_index <= REG_STEREO_ENABLE;
        cfg_data  <= stereo;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rate_mode_q = rate;
        stereo_q    = stereo;
    endtask

    // reset defaults: decimate, stereo
    task automatic test_decimate_directed();
        send_frame(ACT_CLEAR, FULL_SCALE_POS, FULL_SCALE_NEG, 1'b1);
        send_frame(ACT_FRAME, FULL_SCALE_POS, FULL_SCALE_NEG, 1'b0);
        send_frame(ACT_FRAME, '0, '0, 1'b0);
        send_frame(ACT_FRAME, FULL_SCALE_NEG, FULL_SCALE_POS, 1'b0);
        send_frame(ACT_FRAME, 24'sd1, -24'sd1, 1'b0);
        // block end on the even phase: no beat, phase restarts
        send_frame(ACT_FRAME, '0, '0, 1'b1);
        send_frame(ACT_FRAME, 24'sd123, -24'sd456, 1'b0);
        // block end on the odd phase: one beat, phase restarts
        send_frame(ACT_FRAME, -24'sd789, 24'sd321, 1'b1);
        send_frame(ACT_FRAME, FULL_SCALE_POS, FULL_SCALE_POS, 1'b0);
        // clear in mid run drops the pending phase and history
        send_frame(ACT_CLEAR, '0, '0, 1'b0);
        send_frame(ACT_FRAME, FULL_SCALE_NEG, FULL_SCALE_NEG, 1'b0);
        send_frame(ACT_FRAME, '0, '0, 1'b0);
    endtask

    // history carries over from the decimate test
    task automatic test_interpolate_directed();
        set_mode(RATE_INTERPOLATE, CH_STEREO);
        send_frame(ACT_FRAME, FULL_SCALE_POS, FULL_SCALE_NEG, 1'b0);
        send_frame(ACT_FRAME, FULL_SCALE_NEG, FULL_SCALE_POS, 1'b1);
        send_frame(ACT_FRAME, '0, '0, 1'b0);
        send_frame(ACT_CLEAR, FULL_SCALE_POS, FULL_SCALE_POS, 1'b0);
        send_frame(ACT_FRAME, FULL_SCALE_POS, FULL_SCALE_POS, 1'b0);
    endtask

    // right lane ignored and right result zero, in both directions
    task automatic test_mono_directed();
        set_mode(RATE_DECIMATE, CH_MONO);
        send_frame(ACT_FRAME, FULL_SCALE_POS, FULL_SCALE_NEG, 1'b0);
        send_frame(ACT_FRAME, FULL_SCALE_NEG, FULL_SCALE_POS, 1'b1);
        set_mode(RATE_INTERPOLATE, CH_MONO);
        send_frame(ACT_FRAME, FULL_SCALE_NEG, FULL_SCALE_POS, 1'b0);
    endtask

    // run of frames closed by block end, random content
    task automatic send_block_run(output int n);
        int  i;
        int  flavor;
        bit  mixed;
        n      = $urandom_range(1, 40);
        flavor = $urandom_range(FLAVOR_FULL, FLAVOR_EXTREME);
        mixed  = $urandom_range(0, 3) == 0;
        for (i = 0; i < n; i++)
        begin
            if (mixed)
                flavor = $urandom_range(FLAVOR_FULL, FLAVOR_EXTREME);
            send_frame(ACT_FRAME, pick_sample(flavor), pick_sample(flavor), i == n - 1);
        end
    endtask

    // drive the accumulator past full scale: in decimate mode, line the
    // history up with the tap signs; in interpolate mode a steady rail is
    // enough since the zero-stuffed beat sees the center tap at gain 2
    task automatic send_saturating_run(output int n);
        int  j;
        bit  flip_l;
        bit  flip_r;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        flip_l = 1'($urandom_range(0, 1));
        flip_r = 1'($urandom_range(0, 1));
        if (rate_mode_q == RATE_DECIMATE)
        begin
            send_frame(ACT_CLEAR, '0, '0, 1'b0);
            n = TAP_COUNT + 2;
            for (j = 0; j <= TAP_COUNT; j++)
            begin
                // frame j ends up at tap TAP_COUNT - j on the odd beat
                if (j == 0)
                begin
                    l = pick_sample(FLAVOR_FULL);
                    r = pick_sample(FLAVOR_FULL);
                end
                else
                begin
                    l = ((TAP_WEIGHT[TAP_COUNT-j] >= 0) ^ flip_l) ? FULL_SCALE_POS
                                                                  : FULL_SCALE_NEG;
                    r = ((TAP_WEIGHT[TAP_COUNT-j] >= 0) ^ flip_r) ? FULL_SCALE_POS
                                                                  : FULL_SCALE_NEG;
                end
                send_frame(ACT_FRAME, l, r, j == TAP_COUNT);
            end
        end
        else
        begin
            n = $urandom_range(4, 16);
            l = flip_l ? FULL_SCALE_NEG : FULL_SCALE_POS;
            r = flip_r ? FULL_SCALE_NEG : FULL_SCALE_POS;
            for (j = 0; j < n; j++)
                send_frame(ACT_FRAME, l, r, j == n - 1);
        end
    endtask

    // loose beats: stray clears and block ends anywhere
    task automatic send_noise(output int n);
        int   i;
        logic act;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
        begin
            act = ($urandom_range(0, 7) == 0) ? ACT_CLEAR : ACT_FRAME;
            send_frame(act, pick_sample(FLAVOR_FULL), pick_sample(FLAVOR_FULL),
                       1'($urandom_range(0, 1)));
        end
    endtask

    // phases walk all four register settings first, then random ones;
    // every third phase runs without idling
    task automatic test_random_traffic();
        int sent;
        int budget;
        int phase_idx;
        int n;
        int roll;
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_FRAMES)
        begin
            if (phase_idx < 4)
                set_mode(phase_idx[0], phase_idx[1]);
            else
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            gaps_on   = (phase_idx % 3) != 2;
            budget    = $urandom_range(80, 200);
            phase_idx = phase_idx + 1;
            while (budget > 0 && sent < RANDOM_FRAMES)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    send_block_run(n);
                else if (roll < 82)
                    send_saturating_run(n);
                else
                    send_noise(n);
                sent   = sent + n;
                budget = budget - n;
            end
        end
        gaps_on = 1'b1;
    endtask

    // downstream back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (ready_stall > 0)
        begin
            ready_stall = ready_stall - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            ready_stall = pick_gap();
            out_ready <= (ready_stall == 0);
        end
    end

    // every accepted result beat is matched against the oldest owed beat
    always @(posedge clk)
    begin
        audio_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: result beat with none owed: left %0d right %0d last %0b",
                         $time, left_result, right_result, last_of_run);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (left_result !== want.left_val)
                begin
                    $display("%0t: left_result expected %0d actual %0d",
                             $time, want.left_val, left_result);
                    mismatch_count++;
                end
                if (right_result !== want.right_val)
                begin
                    $display("%0t: right_result expected %0d actual %0d",
                             $time, want.right_val, right_result);
                    mismatch_count++;
                end
                if (last_of_run !== want.last_flag)
                begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last_flag, last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        // shadow matches the block's reset state
        clear_history();
        rate_mode_q = RATE_DECIMATE;
        stereo_q    = CH_STEREO;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_decimate_directed();
        test_interpolate_directed();
        test_mono_directed();
        test_random_traffic();

        // drain, then give a late stray beat time to show up
        rest_input();
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_fir_two_to_one_resampler: PASS");
        else
            $display("tb_fir_two_to_one_resampler: FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #50000000;
        $display("tb_fir_two_to_one_resampler: FAIL");
        $finish;
    end

endmodule
